>>> src/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: command and status
// codes, the per-cycle operation handed to every storage cell, default sizes.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEFAULT      = 64;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Fixed widths of the transaction fields
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // Operation broadcast to the cell row for one cycle
  typedef struct packed {
    logic push_front;  // shift toward the back, new value enters cell 0
    logic pop_front;   // shift toward the front
    logic push_back;   // first empty cell takes the new value
    logic pop_back;    // last occupied cell drops its entry
  } cell_op_t;

endpackage

>>> src/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Double-ended queue built as a row of DEPTH shifting cells. Commands push or
// pop at either end or peek at either end; each returns value, status, size.
// ----------------------------------------------------------------------------
// Latency: a transaction accepted at one edge has its result on the result
//   ports, marked by done, for the single cycle that starts at the next edge;
//   out_value, status and size are registered from the execute cycle.
// Busy is high for the execute cycle, in which the cell row shifts and the back
//   entry is selected; start is not taken while busy is high.
// Reset: rst clears the element count, all cell valid bits, busy and done.
// The receiver cannot stall; each result is marked by done for exactly one cycle.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [deq_pkg::CMD_W-1:0]         cmd,
  input  logic signed [deq_pkg::VALUE_W-1:0] push_value,
  output logic                              done,
  output logic signed [deq_pkg::VALUE_W-1:0] out_value,
  output logic [deq_pkg::STATUS_W-1:0]      status,
  output logic [$clog2(DEPTH+1)-1:0]        size
);
  import deq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CMD_W-1:0]      cmd_q;
  logic [DATA_WIDTH-1:0] value_q;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;

  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic [DEPTH-1:0]      cell_valid;
  logic [DEPTH-1:0]      cell_last;

  cell_op_t              op;
  logic                  is_empty;
  logic                  is_full;
  logic [DATA_WIDTH-1:0] back_data;
  logic [DATA_WIDTH-1:0] read_data;
  logic                  read_en;
  status_t               status_next;
  logic [VALUE_W-1:0]    read_ext;

  // Latch the command and fit the push value to the storage width
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= cmd;
      if (DATA_WIDTH <= VALUE_W) begin
        value_q <= push_value[DATA_WIDTH-1:0];
      end else begin
        value_q <= DATA_WIDTH'(push_value);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (busy) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end
  end

  assign is_empty = (count == '0);
  assign is_full  = (count == CNT_W'(DEPTH));

  // Decode the execute-cycle operation
  always_comb begin
    op          = '0;
    read_en     = 1'b0;
    read_data   = cell_data[0];
    status_next = STATUS_OK;
    count_next  = count;
    if (busy) begin
      unique case (cmd_q)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (is_full) begin
            status_next = STATUS_FULL;
          end else begin
            op.push_front = (cmd_q == CMD_PUSH_FRONT);
            op.push_back  = (cmd_q == CMD_PUSH_BACK);
            count_next    = count + CNT_W'(1);
          end
        end
        CMD_POP_FRONT, CMD_PEEK_FRONT: begin
          if (is_empty) begin
            status_next = STATUS_EMPTY;
          end else begin
            read_en      = 1'b1;
            op.pop_front = (cmd_q == CMD_POP_FRONT);
            if (cmd_q == CMD_POP_FRONT) begin
              count_next = count - CNT_W'(1);
            end
          end
        end
        CMD_POP_BACK, CMD_PEEK_BACK: begin
          if (is_empty) begin
            status_next = STATUS_EMPTY;
          end else begin
            read_en     = 1'b1;
            read_data   = back_data;
            op.pop_back = (cmd_q == CMD_POP_BACK);
            if (cmd_q == CMD_POP_BACK) begin
              count_next = count - CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Cell row: cell 0 is the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic                  left_v;
    logic [DATA_WIDTH-1:0] right_d;
    logic                  right_v;

    if (i == 0) begin : g_head
      assign left_d = value_q;
      assign left_v = 1'b1;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
      assign left_v = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_d = '0;
      assign right_v = 1'b0;
    end else begin : g_body
      assign right_d = cell_data[i+1];
      assign right_v = cell_valid[i+1];
    end

    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .new_data    (value_q),
      .left_data   (left_d),
      .left_valid  (left_v),
      .right_data  (right_d),
      .right_valid (right_v),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .is_last     (cell_last[i])
    );
  end

  // Back entry: at most one cell flags itself as last
  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_data = back_data | (cell_data[i] & {DATA_WIDTH{cell_last[i]}});
    end
  end

  // Sign-extend or truncate the stored entry to the result width
  if (DATA_WIDTH >= VALUE_W) begin : g_trunc
    assign read_ext = read_data[VALUE_W-1:0];
  end else begin : g_sext
    assign read_ext = {{(VALUE_W-DATA_WIDTH){read_data[DATA_WIDTH-1]}}, read_data};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      out_value <= read_en ? read_ext : '0;
      status    <= status_next;
      size      <= count_next;
    end
  end

endmodule

>>> src/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// One storage position of the queue row. Entries stay packed toward cell 0:
// cell 0 holds the front, the last occupied cell holds the back.
// ----------------------------------------------------------------------------
module deq_cell #(
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  deq_pkg::cell_op_t     op,
  input  logic [DATA_WIDTH-1:0] new_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic                  left_valid,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic                  right_valid,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  valid,
  output logic                  is_last
);
  import deq_pkg::*;

  assign is_last = valid & ~right_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.push_front) begin
      valid <= left_valid;
    end else if (op.pop_front) begin
      valid <= right_valid;
    end else if (op.push_back && left_valid && !valid) begin
      valid <= 1'b1;
    end else if (op.pop_back && is_last) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op.push_front) begin
      data <= left_data;
    end else if (op.pop_front) begin
      data <= right_data;
    end else if (op.push_back && left_valid && !valid) begin
      data <= new_data;
    end
  end

endmodule
